/* hdl/pal_pkg.sv */
// Shared types, operation and status codes for the positional array list engine.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package pal_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int OP_W         = 4;
  localparam int STAT_W       = 3;
  localparam int VAL_W        = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd4;
  localparam logic [OP_W-1:0] OP_ERASE      = 4'd5;
  localparam logic [OP_W-1:0] OP_FIND       = 4'd6;
  localparam logic [OP_W-1:0] OP_REMOVE     = 4'd7;
  localparam logic [OP_W-1:0] OP_MODIFY     = 4'd8;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // pointer commands
  localparam logic [2:0] PTR_HOLD      = 3'd0;
  localparam logic [2:0] PTR_LOAD_LEN  = 3'd1;
  localparam logic [2:0] PTR_LOAD_POS  = 3'd2;
  localparam logic [2:0] PTR_LOAD_ZERO = 3'd3;
  localparam logic [2:0] PTR_LOAD_TAG  = 3'd4;
  localparam logic [2:0] PTR_INC       = 3'd5;
  localparam logic [2:0] PTR_DEC       = 3'd6;

  // read address relative to the pointer
  localparam logic [1:0] RD_HERE = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_PREV = 2'd2;

  // length commands
  localparam logic [1:0] LEN_HOLD = 2'd0;
  localparam logic [1:0] LEN_INC  = 2'd1;
  localparam logic [1:0] LEN_DEC  = 2'd2;

  typedef struct packed {
    logic              capture;
    logic              pos_zero;
    logic [2:0]        ptr_op;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              wr_pend;
    logic              wr_val;
    logic [1:0]        len_op;
    logic              status_wr;
    logic [STAT_W-1:0] status_code;
    logic              match_set;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic len_full;
    logic pos_gt_len;
    logic pos_ge_len;
    logic ptr_gt_pos;
    logic more_down;
    logic more_srch;
    logic pend;
    logic hit;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/pal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/pal_dp.sv */
// Datapath of the list engine: entry RAM, length, pointer and result registers.
// Depends on pal_pkg and pal_ram.
`default_nettype none

module pal_dp #(
  parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire pal_pkg::dp_cmd_t                     cmd,
  output pal_pkg::dp_stat_t                         stat,
  input  wire logic        [$clog2(CAPACITY+1)-1:0] in_position,
  input  wire logic signed [pal_pkg::VAL_W-1:0]     in_value,
  output logic             [pal_pkg::STAT_W-1:0]    out_status,
  output logic             [$clog2(CAPACITY)-1:0]   out_match_index,
  output logic             [$clog2(CAPACITY+1)-1:0] out_entry_count
);
  import pal_pkg::*;

  localparam int POS_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic        [POS_W-1:0]  len_r, len_nxt;
  logic        [POS_W-1:0]  ptr_r, ptr_nxt;
  logic        [POS_W-1:0]  tag_r;
  logic        [POS_W-1:0]  pos_r;
  logic signed [VAL_W-1:0]  val_r;
  logic                     pend_r;
  logic        [STAT_W-1:0] status_r;
  logic        [IDX_W-1:0]  match_r;

  logic        [POS_W-1:0]  rd_ptr;
  logic        [POS_W:0]    ptr_plus1;
  logic                     ram_we;
  logic        [IDX_W-1:0]  ram_waddr;
  logic        [VAL_W-1:0]  ram_wdata;
  logic        [VAL_W-1:0]  ram_rdata;

  assign ptr_plus1 = {1'b0, ptr_r} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NEXT: rd_ptr = ptr_plus1[POS_W-1:0];
      RD_PREV: rd_ptr = ptr_r - POS_W'(1);
      default: rd_ptr = ptr_r;
    endcase
  end

  // a pending shifted entry takes the write port ahead of the new value
  assign ram_we    = cmd.wr_pend | cmd.wr_val;
  assign ram_waddr = cmd.wr_pend ? tag_r[IDX_W-1:0] : ptr_r[IDX_W-1:0];
  assign ram_wdata = cmd.wr_pend ? ram_rdata : $unsigned(val_r);

  pal_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cmd.ptr_op)
      PTR_LOAD_LEN:  ptr_nxt = len_r;
      PTR_LOAD_POS:  ptr_nxt = in_position;
      PTR_LOAD_ZERO: ptr_nxt = '0;
      PTR_LOAD_TAG:  ptr_nxt = tag_r;
      PTR_INC:       ptr_nxt = ptr_plus1[POS_W-1:0];
      PTR_DEC:       ptr_nxt = ptr_r - POS_W'(1);
      default:       ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    unique case (cmd.len_op)
      LEN_INC: len_nxt = len_r + POS_W'(1);
      LEN_DEC: len_nxt = len_r - POS_W'(1);
      default: len_nxt = len_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      pend_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.rd_en) begin
      tag_r <= ptr_r;
    end
    if (cmd.capture) begin
      pos_r   <= cmd.pos_zero ? '0 : in_position;
      val_r   <= in_value;
      match_r <= '0;
    end else if (cmd.match_set) begin
      match_r <= tag_r[IDX_W-1:0];
    end
    if (cmd.status_wr) begin
      status_r <= cmd.status_code;
    end
  end

  always_comb begin
    stat.len_zero   = (len_r == '0);
    stat.len_full   = (len_r == POS_W'(CAPACITY));
    stat.pos_gt_len = (in_position > len_r);
    stat.pos_ge_len = (in_position >= len_r);
    stat.ptr_gt_pos = (ptr_r > pos_r);
    stat.more_down  = (ptr_plus1 < {1'b0, len_r});
    stat.more_srch  = (ptr_r < len_r);
    stat.pend       = pend_r;
    stat.hit        = pend_r && (ram_rdata == $unsigned(val_r));
  end

  assign out_status      = status_r;
  assign out_match_index = match_r;
  assign out_entry_count = len_r;

endmodule

`default_nettype wire

/* hdl/pal_ctrl.sv */
// Controller of the list engine: decodes the operation and sequences shifts and searches.
// Depends on pal_pkg.
`default_nettype none

module pal_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [pal_pkg::OP_W-1:0] in_operation,
  input  wire pal_pkg::dp_stat_t        stat,
  output pal_pkg::dp_cmd_t              cmd,
  output logic                          out_valid
);
  import pal_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WRV  = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_PUSH_BACK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture   = 1'b1;
          cmd.status_wr = 1'b1;
          op_nxt        = in_operation;
          state_nxt     = S_DONE;
          unique case (in_operation)
            OP_PUSH_BACK: begin
              if (stat.len_full) begin
                cmd.status_code = ST_FULL;
              end else begin
                cmd.ptr_op = PTR_LOAD_LEN;
                state_nxt  = S_WRV;
              end
            end
            OP_POP_BACK: begin
              if (stat.len_zero) begin
                cmd.status_code = ST_EMPTY;
              end else begin
                cmd.len_op = LEN_DEC;
              end
            end
            OP_PUSH_FRONT: begin
              if (stat.len_full) begin
                cmd.status_code = ST_FULL;
              end else begin
                cmd.pos_zero = 1'b1;
                cmd.ptr_op   = PTR_LOAD_LEN;
                state_nxt    = S_SHUP;
              end
            end
            OP_POP_FRONT: begin
              if (stat.len_zero) begin
                cmd.status_code = ST_EMPTY;
              end else begin
                cmd.ptr_op = PTR_LOAD_ZERO;
                state_nxt  = S_SHDN;
              end
            end
            OP_INSERT: begin
              if (stat.len_full) begin
                cmd.status_code = ST_FULL;
              end else if (stat.pos_gt_len) begin
                cmd.status_code = ST_BADPOS;
              end else begin
                cmd.ptr_op = PTR_LOAD_LEN;
                state_nxt  = S_SHUP;
              end
            end
            OP_ERASE: begin
              if (stat.len_zero) begin
                cmd.status_code = ST_EMPTY;
              end else if (stat.pos_ge_len) begin
                cmd.status_code = ST_BADPOS;
              end else begin
                cmd.ptr_op = PTR_LOAD_POS;
                state_nxt  = S_SHDN;
              end
            end
            OP_FIND, OP_REMOVE: begin
              cmd.ptr_op = PTR_LOAD_ZERO;
              state_nxt  = S_SRCH;
            end
            OP_MODIFY: begin
              if (stat.len_zero) begin
                cmd.status_code = ST_EMPTY;
              end else if (stat.pos_ge_len) begin
                cmd.status_code = ST_BADPOS;
              end else begin
                cmd.ptr_op = PTR_LOAD_POS;
                state_nxt  = S_WRV;
              end
            end
            default: ;
          endcase
        end
      end
      S_WRV: begin
        cmd.wr_val = 1'b1;
        cmd.len_op = (op_r == OP_PUSH_BACK) ? LEN_INC : LEN_HOLD;
        state_nxt  = S_DONE;
      end
      S_SHUP: begin
        // move entries up one slot, top first, then drop the value into the gap
        cmd.wr_pend = stat.pend;
        if (stat.ptr_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          cmd.ptr_op = PTR_DEC;
        end else if (!stat.pend) begin
          cmd.wr_val = 1'b1;
          cmd.len_op = LEN_INC;
          state_nxt  = S_DONE;
        end
      end
      S_SHDN: begin
        // move entries down one slot, bottom first
        cmd.wr_pend = stat.pend;
        if (stat.more_down) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          cmd.ptr_op = PTR_INC;
        end else if (!stat.pend) begin
          cmd.len_op = LEN_DEC;
          state_nxt  = S_DONE;
        end
      end
      S_SRCH: begin
        if (stat.hit) begin
          cmd.match_set = 1'b1;
          if (op_r == OP_REMOVE) begin
            cmd.ptr_op = PTR_LOAD_TAG;
            state_nxt  = S_SHDN;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.more_srch) begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = PTR_INC;
        end else if (!stat.pend) begin
          cmd.status_wr   = 1'b1;
          cmd.status_code = ST_NOTFOUND;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/positional_array_list_engine_unit.sv */
// Top level of the positional array list engine: controller plus datapath.
// Depends on pal_pkg, pal_ctrl, pal_dp (and pal_ram through pal_dp).
//
//   channel   ports                                              handshake
//   -------   ------------------------------------------------   ------------------------
//   input     in_operation, in_position, in_value                start high, busy low
//   result    out_status, out_match_index, out_entry_count       out_valid, one cycle
//
// An item is taken only while busy is low; one item finishes before the next is taken.
// Pop_back, push_back, modify and refused items shift nothing. Insert/push_front move the
// entries at and above the position up, erase/pop_front those above it down; find/remove
// scan from the front, a remove then closing the gap; shifts move one entry per cycle.
// Reset is synchronous, active low, and empties the list; the entry RAM is not cleared.
// The result shows on out_valid for one cycle; the receiver cannot stall it.
`default_nettype none

module positional_array_list_engine_unit #(
  parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [pal_pkg::OP_W-1:0]      in_operation,
  input  wire logic        [$clog2(CAPACITY+1)-1:0] in_position,
  input  wire logic signed [pal_pkg::VAL_W-1:0]     in_value,
  output logic                                      out_valid,
  output logic             [pal_pkg::STAT_W-1:0]    out_status,
  output logic             [$clog2(CAPACITY)-1:0]   out_match_index,
  output logic             [$clog2(CAPACITY+1)-1:0] out_entry_count
);
  import pal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence each operation; results are held in datapath registers
  pal_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .out_valid    (out_valid)
  );

  // entry storage, length, scan pointer and result registers
  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_match_index (out_match_index),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

/* hdl/pal_chk.sv */
// Port-level checker for the list engine, bound to the top level.
// Depends on pal_pkg and positional_array_list_engine_unit.
`default_nettype none

module pal_chk #(
  parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             out_valid,
  input wire logic [pal_pkg::STAT_W-1:0]       out_status,
  input wire logic [$clog2(CAPACITY+1)-1:0]    out_entry_count
);
  import pal_pkg::*;

  // an accepted item keeps the engine busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accept did not raise busy");

  // the result goes out while busy, and the engine is free right after
  a_result_then_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy ##1 !busy))
    else $error("result strobe not followed by idle");

  // an idle cycle without a new item leaves the count alone
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> $stable(out_entry_count))
    else $error("entry count moved while idle");

  // a refused push reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (out_entry_count == ($clog2(CAPACITY+1))'(CAPACITY)))
    else $error("full status with list not full");

  // a refused pop reports an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with entries held");

endmodule

bind positional_array_list_engine_unit pal_chk #(
  .CAPACITY (CAPACITY)
) u_pal_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for positional_array_list_engine_unit: directed table, then random list traffic.
// Uses pal_pkg for widths, operation and status codes.
// A shadow list in the bench predicts status, match index and entry count.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int POS_W        = $clog2(CAP + 1);
  localparam int IDX_W        = $clog2(CAP);
  localparam int RANDOM_ITEMS = 1100;
  // Slowest item is a remove at full length: a search plus a shift.
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 2 * CAP + 8;

  // Codes 9..15 are unused operations; the engine must answer them with ok.
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 4'd9;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 4'd15;

  // Values that repeat often, so finds and removes see duplicates and extremes.
  localparam logic [VAL_W-1:0] VALUE_POOL [6] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A
  };

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  match_index;
    logic [POS_W-1:0]  entry_count;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             known;   // expected result typed into the table
    list_result_t     want;
  } list_cmd_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_operation = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic [IDX_W-1:0]        out_match_index;
  logic [POS_W-1:0]        out_entry_count;

  positional_array_list_engine_unit #(.CAPACITY(CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_match_index (out_match_index),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the list, advanced once per accepted item.
  logic [VAL_W-1:0] shadow_entries [CAP];
  int               shadow_len = 0;

  list_result_t     pending_results [$];
  list_cmd_t        directed_rows [$];
  int               mismatch_count = 0;
  int               idle_cycles = 0;
  bit               idle_on = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Shift entries at+1..len-1 down by one over the entry at, and drop the last slot.
  function automatic void close_gap(input int at);
    int i;
    for (i = at; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_len--;
  endfunction

  // Apply one list operation to the shadow list and return the result it gives.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t r;
    int           i;
    int           hit;
    int           at;
    r   = '0;
    hit = -1;
    at  = int'(pos);
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (op == OP_PUSH_BACK) at = shadow_len;
        else if (op == OP_PUSH_FRONT) at = 0;
        // Fullness wins over a bad insert position.
        if (shadow_len >= CAP) r.status = ST_FULL;
        else if (at > shadow_len) r.status = ST_BADPOS;
        else begin
          for (i = shadow_len; i > at; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[at] = val;
          shadow_len++;
        end
      end
      OP_POP_BACK: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len--;
      end
      OP_POP_FRONT: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else close_gap(0);
      end
      OP_ERASE, OP_MODIFY: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else if (at >= shadow_len) r.status = ST_BADPOS;
        else if (op == OP_ERASE) close_gap(at);
        else shadow_entries[at] = val;
      end
      OP_FIND, OP_REMOVE: begin
        for (i = 0; i < shadow_len && hit < 0; i++)
          if (shadow_entries[i] == val) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else begin
          r.match_index = IDX_W'(hit);
          if (op == OP_REMOVE) close_gap(hit);
        end
      end
      default: ;
    endcase
    r.entry_count = POS_W'(shadow_len);
    return r;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val, input logic known,
                         input logic [STAT_W-1:0] st, input int mi, input int ec);
    list_cmd_t row;
    row.op                 = op;
    row.pos                = pos;
    row.val                = val;
    row.known              = known;
    row.want.status        = st;
    row.want.match_index   = IDX_W'(mi);
    row.want.entry_count   = POS_W'(ec);
    directed_rows.push_back(row);
  endtask

  // Drive one item, hold it until the engine takes it, then queue its expected result.
  task automatic issue_item(input list_cmd_t cmd);
    list_result_t pred;
    int           gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= cmd.op;
    in_position  <= cmd.pos;
    in_value     <= cmd.val;
    // busy read here is the value of the cycle this edge closes.
    do @(posedge clk); while (busy);
    pred = apply_list_op(cmd.op, cmd.pos, cmd.val);
    pending_results.push_back(cmd.known ? cmd.want : pred);
  endtask

  // Random traffic that drifts the length between empty and full, so both
  // ends get hit repeatedly; finds and removes mostly search for held values.
  task automatic run_random_items(input int count);
    list_cmd_t cmd;
    bit        growing;
    int        n;
    int        pick;
    int        grow_w;
    int        shrink_w;
    growing = 1'b1;
    for (n = 0; n < count; n++) begin
      if (shadow_len >= CAP && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (shadow_len == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 2) growing = ~growing;
      // Alternate stretches with random gaps and back-to-back items.
      if (n % 40 == 0) idle_on = 1'($urandom_range(0, 1));

      grow_w   = growing ? 50 : 15;
      shrink_w = growing ? 15 : 50;
      pick     = $urandom_range(0, 99);
      cmd      = '0;
      if (pick < 4) cmd.op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      else if (pick < 4 + grow_w) begin
        case ($urandom_range(0, 2))
          0:       cmd.op = OP_PUSH_BACK;
          1:       cmd.op = OP_PUSH_FRONT;
          default: cmd.op = OP_INSERT;
        endcase
      end else if (pick < 4 + grow_w + shrink_w) begin
        case ($urandom_range(0, 3))
          0:       cmd.op = OP_POP_BACK;
          1:       cmd.op = OP_POP_FRONT;
          2:       cmd.op = OP_ERASE;
          default: cmd.op = OP_REMOVE;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd.op = OP_FIND;
          1:       cmd.op = OP_MODIFY;
          default: cmd.op = OP_REMOVE;
        endcase
      end

      // Mostly legal positions, some at the boundary, a few anywhere in range.
      pick = $urandom_range(0, 9);
      if (pick == 0) cmd.pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      else if (pick == 1) cmd.pos = POS_W'(shadow_len);
      else cmd.pos = POS_W'($urandom_range(0, shadow_len > 0 ? shadow_len - 1 : 0));

      pick = $urandom_range(0, 9);
      if ((cmd.op == OP_FIND || cmd.op == OP_REMOVE) && shadow_len > 0 && pick < 7)
        cmd.val = shadow_entries[$urandom_range(0, shadow_len - 1)];
      else if (pick < 4) cmd.val = VALUE_POOL[$urandom_range(0, 5)];
      else cmd.val = $urandom();

      issue_item(cmd);
    end
  endtask

  initial begin : stimulus
    int k;
    // Directed rows: typed results where they are obvious, predictor for the rest.
    add_row(OP_POP_BACK,   0,   32'h0,         1, ST_EMPTY,    0, 0);
    add_row(OP_POP_FRONT,  0,   32'h0,         1, ST_EMPTY,    0, 0);
    add_row(OP_ERASE,      0,   32'h0,         1, ST_EMPTY,    0, 0);
    add_row(OP_MODIFY,     0,   32'h1,         1, ST_EMPTY,    0, 0);
    add_row(OP_FIND,       0,   32'h0,         1, ST_NOTFOUND, 0, 0);
    add_row(OP_REMOVE,     0,   32'h0,         1, ST_NOTFOUND, 0, 0);
    add_row(OP_INSERT,     1,   32'h1,         1, ST_BADPOS,   0, 0);
    add_row(OP_INSERT,     127, 32'h1,         1, ST_BADPOS,   0, 0);
    add_row(OP_INSERT,     0,   32'h8000_0000, 1, ST_OK,       0, 1);
    add_row(OP_PUSH_BACK,  0,   32'h7FFF_FFFF, 1, ST_OK,       0, 2);
    add_row(OP_PUSH_FRONT, 0,   32'h0,         1, ST_OK,       0, 3);
    add_row(OP_INSERT,     3,   32'hFFFF_FFFF, 1, ST_OK,       0, 4);
    add_row(OP_FIND,       0,   32'h7FFF_FFFF, 1, ST_OK,       2, 4);
    add_row(OP_FIND,       0,   32'h1,         1, ST_NOTFOUND, 0, 4);
    add_row(OP_MODIFY,     4,   32'h1,         1, ST_BADPOS,   0, 4);
    add_row(OP_MODIFY,     0,   32'hFFFF_FFFF, 1, ST_OK,       0, 4);
    add_row(OP_FIND,       0,   32'hFFFF_FFFF, 1, ST_OK,       0, 4);
    add_row(OP_REMOVE,     0,   32'hFFFF_FFFF, 1, ST_OK,       0, 3);
    add_row(OP_ERASE,      127, 32'h0,         1, ST_BADPOS,   0, 3);
    add_row(OP_ERASE,      1,   32'h0,         1, ST_OK,       0, 2);
    add_row(OP_RSVD_FIRST, 0,   32'h0,         1, ST_OK,       0, 2);
    add_row(OP_RSVD_LAST,  127, 32'hFFFF_FFFF, 1, ST_OK,       0, 2);
    add_row(OP_INSERT,     1,   32'h5A5A_5A5A, 0, ST_OK,       0, 0);
    add_row(OP_REMOVE,     0,   32'hFFFF_FFFF, 0, ST_OK,       0, 0);
    add_row(OP_POP_FRONT,  0,   32'h0,         0, ST_OK,       0, 0);
    add_row(OP_POP_BACK,   0,   32'h0,         0, ST_OK,       0, 0);

    // Hold reset low from time zero, then release it for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < directed_rows.size(); k++) issue_item(directed_rows[k]);
    run_random_items(RANDOM_ITEMS);
    start <= 1'b0;

    // Drain: wait for every expected result, then allow stray ones to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Compare each strobed result against the oldest expectation.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (status %0d count %0d)",
                                  out_status, out_entry_count));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", out_status, want.status));
        if (out_match_index !== want.match_index)
          report_mismatch($sformatf("match_index got %0d expected %0d",
                                    out_match_index, want.match_index));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count got %0d expected %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  // Watchdog: end the run if neither an item nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

`default_nettype wire
